// ===== rtl/cellrc_pkg.sv =====
package cellrc_pkg;

    localparam int LEN_WIDTH_DEF      = 20;
    localparam int CELL_SEQ_WIDTH_DEF = 16;

    localparam int SRC_W      = 8;
    localparam int DST_W      = 8;
    localparam int MSG_W      = 32;
    localparam int CSEQ_W     = 16;
    localparam int PAY_W      = 12;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 20;
    localparam int KIND_W     = 2;

    // cell class, worked out at the front
    localparam logic [KIND_W-1:0] KIND_CONT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONT_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SOLO     = 2'd3;

    typedef struct packed {
        logic [SRC_W-1:0]  source_id;
        logic [DST_W-1:0]  dest_id;
        logic [MSG_W-1:0]  msg_seq;
        logic [CSEQ_W-1:0] cell_seq;
        logic [PAY_W-1:0]  payload_bits;
        logic              is_start;
        logic              is_end;
        logic [TIME_W-1:0] time_stamp;
    } cell_t;

    typedef struct packed {
        logic [SRC_W-1:0]   out_source;
        logic [DST_W-1:0]   out_dest;
        logic [MSG_W-1:0]   out_msg_seq;
        logic [TIME_W-1:0]  out_time;
        logic [TOTAL_W-1:0] total_bits;
    } pkt_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source_id;
        logic [DST_W-1:0]  dest_id;
        logic [MSG_W-1:0]  msg_seq;
        logic [PAY_W-1:0]  payload_bits;
        logic [TIME_W-1:0] time_stamp;
        logic [KIND_W-1:0] kind;
    } qent_t;

endpackage

// ===== rtl/cell_reassembly_checker.sv =====
// Channel  Direction  Handshake               Payload
// cell     in         cell_valid/cell_ready   cellrc_pkg::cell_t
// pkt      out        pkt_valid/pkt_ready     cellrc_pkg::pkt_t
//
// One cell per cycle sustained while the output is not stalled; a packet is
// valid once its end cell has been transferred and has passed through a queue
// slot and then the output register.
// Rate is set by the state update in the back end.
// rst_n clears the queue, the reassembly state and the output valid flag.
// A stalled output holds the back end; the two-slot queue then fills and
// cell_ready drops.
module cell_reassembly_checker #(
    parameter int LEN_WIDTH      = cellrc_pkg::LEN_WIDTH_DEF,
    parameter int CELL_SEQ_WIDTH = cellrc_pkg::CELL_SEQ_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cell_valid,
    output logic              cell_ready,
    input  cellrc_pkg::cell_t cell_data,
    output logic              pkt_valid,
    input  logic              pkt_ready,
    output cellrc_pkg::pkt_t  pkt
);

    cellrc_pkg::qent_t         head;
    logic [CELL_SEQ_WIDTH-1:0] head_seq;
    logic                      head_valid;
    logic                      head_pop;

    cellrc_front #(
        .CELL_SEQ_WIDTH (CELL_SEQ_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .head       (head),
        .head_seq   (head_seq),
        .head_pop   (head_pop),
        .head_valid (head_valid)
    );

    cellrc_back #(
        .LEN_WIDTH      (LEN_WIDTH),
        .CELL_SEQ_WIDTH (CELL_SEQ_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_seq   (head_seq),
        .head_pop   (head_pop),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt),
        .head_valid (head_valid)
    );

endmodule

// ===== rtl/cellrc_front.sv =====
module cellrc_front #(
    parameter int CELL_SEQ_WIDTH = cellrc_pkg::CELL_SEQ_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cell_valid,
    output logic                      cell_ready,
    input  cellrc_pkg::cell_t         cell_data,
    output cellrc_pkg::qent_t         head,
    output logic [CELL_SEQ_WIDTH-1:0] head_seq,
    input  logic                      head_pop,
    output logic                      head_valid
);

    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    cellrc_pkg::qent_t         slot0_reg;
    cellrc_pkg::qent_t         slot1_reg;
    logic [CELL_SEQ_WIDTH-1:0] seq0_reg;
    logic [CELL_SEQ_WIDTH-1:0] seq1_reg;

    cellrc_pkg::qent_t                         new_ent;
    logic [CELL_SEQ_WIDTH-1:0]                 new_seq;
    logic [CELL_SEQ_WIDTH+cellrc_pkg::CSEQ_W-1:0] seq_ext;
    logic                                      push;
    logic                                      pop;

    // take the low bits of the cell index, zero-extended when the counter is wider
    assign seq_ext = {{CELL_SEQ_WIDTH{1'b0}}, cell_data.cell_seq};
    assign new_seq = seq_ext[CELL_SEQ_WIDTH-1:0];

    always_comb
    begin
        new_ent.source_id    = cell_data.source_id;
        new_ent.dest_id      = cell_data.dest_id;
        new_ent.msg_seq      = cell_data.msg_seq;
        new_ent.payload_bits = cell_data.payload_bits;
        new_ent.time_stamp   = cell_data.time_stamp;
        if (cell_data.is_start && cell_data.is_end)
            new_ent.kind = cellrc_pkg::KIND_SOLO;
        else if (cell_data.is_start)
            new_ent.kind = cellrc_pkg::KIND_START;
        else if (cell_data.is_end)
            new_ent.kind = cellrc_pkg::KIND_CONT_END;
        else
            new_ent.kind = cellrc_pkg::KIND_CONT;
    end

    assign cell_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign push       = cell_valid && cell_ready;
    assign pop        = head_pop && head_valid;
    assign head       = slot0_reg;
    assign head_seq   = seq0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // two-slot queue, head always in slot 0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == 2'd1)
            begin
                slot0_reg <= new_ent;
                seq0_reg  <= new_seq;
            end
            else
            begin
                slot0_reg <= slot1_reg;
                seq0_reg  <= seq1_reg;
            end
            if (push && count_reg == 2'd2)
            begin
                slot1_reg <= new_ent;
                seq1_reg  <= new_seq;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= new_ent;
                seq0_reg  <= new_seq;
            end
            else
            begin
                slot1_reg <= new_ent;
                seq1_reg  <= new_seq;
            end
        end
    end

endmodule

// ===== rtl/cellrc_back.sv =====
module cellrc_back #(
    parameter int LEN_WIDTH      = cellrc_pkg::LEN_WIDTH_DEF,
    parameter int CELL_SEQ_WIDTH = cellrc_pkg::CELL_SEQ_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cellrc_pkg::qent_t         head,
    input  logic [CELL_SEQ_WIDTH-1:0] head_seq,
    output logic                      head_pop,
    output logic                      pkt_valid,
    input  logic                      pkt_ready,
    output cellrc_pkg::pkt_t          pkt,
    input  logic                      head_valid
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [cellrc_pkg::MSG_W-1:0] expect_msg_reg;
    logic [cellrc_pkg::MSG_W-1:0] expect_msg_next;
    logic [CELL_SEQ_WIDTH-1:0] prev_cell_reg;
    logic [CELL_SEQ_WIDTH-1:0] prev_cell_next;
    logic [LEN_WIDTH-1:0]      length_reg;
    logic [LEN_WIDTH-1:0]      length_next;
    logic                      pkt_valid_reg;
    logic                      pkt_valid_next;
    cellrc_pkg::pkt_t          pkt_reg;

    logic                      step;
    logic                      emit;
    logic                      cont_ok;
    logic [LEN_WIDTH-1:0]      pay_ext;
    logic [LEN_WIDTH:0]        sum_wide;
    logic [LEN_WIDTH-1:0]      sum_sat;
    logic [LEN_WIDTH-1:0]      emit_len;
    logic [LEN_WIDTH+cellrc_pkg::TOTAL_W-1:0] len_ext;

    // advance whenever the output register is free or being emptied
    assign step     = head_valid && (!pkt_valid_reg || pkt_ready);
    assign head_pop = step;

    assign pay_ext  = LEN_WIDTH'(head.payload_bits);
    assign sum_wide = {1'b0, length_reg} + {1'b0, pay_ext};
    assign sum_sat  = sum_wide[LEN_WIDTH] ? {LEN_WIDTH{1'b1}} : sum_wide[LEN_WIDTH-1:0];
    assign cont_ok  = busy_reg && (head.msg_seq == expect_msg_reg)
                      && (head_seq == CELL_SEQ_WIDTH'(prev_cell_reg + 1'b1));

    always_comb
    begin
        busy_next       = busy_reg;
        expect_msg_next = expect_msg_reg;
        prev_cell_next  = prev_cell_reg;
        length_next     = length_reg;
        emit            = 1'b0;
        emit_len        = pay_ext;
        if (step)
        begin
            case (head.kind)
                cellrc_pkg::KIND_START:
                begin
                    busy_next       = 1'b1;
                    expect_msg_next = head.msg_seq;
                    prev_cell_next  = head_seq;
                    length_next     = pay_ext;
                end
                cellrc_pkg::KIND_SOLO:
                begin
                    emit     = 1'b1;
                    emit_len = pay_ext;
                end
                cellrc_pkg::KIND_CONT:
                begin
                    if (cont_ok)
                    begin
                        prev_cell_next = head_seq;
                        length_next    = sum_sat;
                    end
                end
                cellrc_pkg::KIND_CONT_END:
                begin
                    if (cont_ok)
                    begin
                        emit     = 1'b1;
                        emit_len = sum_sat;
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
            // a finished packet drops the reassembly back to idle
            if (emit)
            begin
                busy_next       = 1'b0;
                expect_msg_next = {cellrc_pkg::MSG_W{1'b1}};
                prev_cell_next  = {CELL_SEQ_WIDTH{1'b1}};
                length_next     = '0;
            end
        end
    end

    always_comb
    begin
        pkt_valid_next = pkt_valid_reg;
        if (emit)
            pkt_valid_next = 1'b1;
        else if (pkt_ready)
            pkt_valid_next = 1'b0;
    end

    assign len_ext = {{cellrc_pkg::TOTAL_W{1'b0}}, emit_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            expect_msg_reg <= {cellrc_pkg::MSG_W{1'b1}};
            prev_cell_reg  <= {CELL_SEQ_WIDTH{1'b1}};
            length_reg     <= '0;
            pkt_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            expect_msg_reg <= expect_msg_next;
            prev_cell_reg  <= prev_cell_next;
            length_reg     <= length_next;
            pkt_valid_reg  <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pkt_reg.out_source  <= head.source_id;
            pkt_reg.out_dest    <= head.dest_id;
            pkt_reg.out_msg_seq <= head.msg_seq;
            pkt_reg.out_time    <= head.time_stamp;
            pkt_reg.total_bits  <= len_ext[cellrc_pkg::TOTAL_W-1:0];
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

// ===== rtl/cellrc_checker.sv =====
module cellrc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cell_valid,
    input logic              cell_ready,
    input cellrc_pkg::cell_t cell_data,
    input logic              pkt_valid,
    input logic              pkt_ready,
    input cellrc_pkg::pkt_t  pkt
);

    // hold a stalled packet
    a_pkt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
        else $error("packet changed or vanished while stalled");

    // no packet once reset has been seen
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !pkt_valid)
        else $error("packet valid after reset");

    // queue starts empty after reset
    a_ready_after_reset: assert property (@(posedge clk)
        rst_n && $past(!rst_n) |-> cell_ready)
        else $error("cell_ready low straight after reset");

    // back-pressure only comes from a stalled output
    a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ready |-> pkt_valid && $past(pkt_valid && !pkt_ready))
        else $error("cell_ready low without an output stall");

endmodule

bind cell_reassembly_checker cellrc_checker u_cellrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_data  (cell_data),
    .pkt_valid  (pkt_valid),
    .pkt_ready  (pkt_ready),
    .pkt        (pkt)
);

// ===== bench/cell_reassembly_checker_tb.sv =====
module cell_reassembly_checker_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CELL_COUNT  = 1440;
    localparam int CALM_TAIL   = 150;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cell_valid = 1'b0;
    logic              cell_ready;
    cellrc_pkg::cell_t cell_data  = '0;
    logic              pkt_valid;
    logic              pkt_ready  = 1'b0;
    cellrc_pkg::pkt_t  pkt;

    cell_reassembly_checker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt)
    );

    cellrc_pkg::cell_t cell_backlog[$];
    cellrc_pkg::pkt_t  pkts_owed[$];
    int    cells_total = 0;
    int    cells_taken = 0;
    int    cycle_count = 0;
    bit    failed      = 1'b0;

    // reassembly state as the block should hold it
    logic                            asm_busy = 1'b0;
    logic [cellrc_pkg::MSG_W-1:0]    asm_msg  = '1;
    logic [cellrc_pkg::CSEQ_W-1:0]   asm_cell = '1;
    logic [cellrc_pkg::TOTAL_W-1:0]  asm_bits = '0;

    // idling control for each side
    int tx_gap       = 0;
    int tx_mode      = 0;
    int tx_mode_left = 0;
    int rx_gap       = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit calm();
        return cell_backlog.size() < CALM_TAIL;
    endfunction

    function automatic void reassemble_cell(input cellrc_pkg::cell_t c);
        logic [cellrc_pkg::CSEQ_W-1:0]  next_seq;
        logic [cellrc_pkg::TOTAL_W-1:0] base;
        logic [cellrc_pkg::TOTAL_W:0]   sum;
        cellrc_pkg::pkt_t               p;
        next_seq = asm_cell + 1'b1;
        // drop continuations that do not follow on
        if (!c.is_start && (!asm_busy || c.msg_seq != asm_msg || c.cell_seq != next_seq))
            return;
        base = c.is_start ? '0 : asm_bits;
        sum  = {1'b0, base}
               + {{(cellrc_pkg::TOTAL_W + 1 - cellrc_pkg::PAY_W){1'b0}}, c.payload_bits};
        asm_bits = sum[cellrc_pkg::TOTAL_W] ? '1 : sum[cellrc_pkg::TOTAL_W-1:0];
        asm_busy = 1'b1;
        asm_msg  = c.msg_seq;
        asm_cell = c.cell_seq;
        if (c.is_end)
        begin
            p.out_source  = c.source_id;
            p.out_dest    = c.dest_id;
            p.out_msg_seq = c.msg_seq;
            p.out_time    = c.time_stamp;
            p.total_bits  = asm_bits;
            pkts_owed.push_back(p);
            asm_busy = 1'b0;
            asm_msg  = '1;
            asm_cell = '1;
            asm_bits = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // fields arrive as 32-bit values and keep their low bits
    function automatic cellrc_pkg::cell_t make_cell(input logic [31:0] src,
                                                    input logic [31:0] dst,
                                                    input logic [31:0] msg,
                                                    input logic [31:0] cseq,
                                                    input logic [31:0] pay,
                                                    input logic st, input logic en,
                                                    input logic [31:0] ts);
        cellrc_pkg::cell_t c;
        c.source_id    = src[cellrc_pkg::SRC_W-1:0];
        c.dest_id      = dst[cellrc_pkg::DST_W-1:0];
        c.msg_seq      = msg[cellrc_pkg::MSG_W-1:0];
        c.cell_seq     = cseq[cellrc_pkg::CSEQ_W-1:0];
        c.payload_bits = pay[cellrc_pkg::PAY_W-1:0];
        c.is_start     = st;
        c.is_end       = en;
        c.time_stamp   = ts[cellrc_pkg::TIME_W-1:0];
        return c;
    endfunction

    function automatic cellrc_pkg::cell_t cell_of(input logic [31:0] msg,
                                                  input logic [31:0] cseq,
                                                  input logic [31:0] pay, input logic st,
                                                  input logic en);
        return make_cell($urandom, $urandom, msg, cseq, pay, st, en, $urandom);
    endfunction

    task automatic queue_message(input int n, input bit noisy, input bit max_pay);
        logic [31:0] msg;
        logic [31:0] seq;
        logic [31:0] pay;
        int          k;
        case ($urandom_range(0, 7))
            0:       msg = '0;
            1:       msg = '1;
            default: msg = $urandom;
        endcase
        seq = ($urandom_range(0, 3) == 0) ? 32'hFFFF - $urandom_range(0, 3) : $urandom;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 7))
                0:       pay = '0;
                1:       pay = '1;
                default: pay = $urandom;
            endcase
            if (max_pay)
                pay = '1;
            if (noisy && k > 0 && $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: cell_backlog.push_back(cell_of(msg ^ (32'h1 << $urandom_range(0, 31)),
                                                      seq, pay, 1'b0,
                                                      $urandom_range(0, 1) != 0));
                    1: cell_backlog.push_back(cell_of(msg, seq - 1'b1, pay, 1'b0,
                                                      $urandom_range(0, 1) != 0));
                    2: cell_backlog.push_back(cell_of(msg, seq + 1'b1, pay, 1'b0,
                                                      $urandom_range(0, 1) != 0));
                    // cut the message short; the next start abandons it
                    default: return;
                endcase
            end
            cell_backlog.push_back(cell_of(msg, seq, pay, k == 0, k == n - 1));
            seq = seq + 1'b1;
        end
    endtask

    initial
    begin
        bit sat_done;
        sat_done = 1'b0;

        cell_backlog.push_back(make_cell('0, '0, '0, '0, '0, 1'b1, 1'b1, '0));
        cell_backlog.push_back(make_cell('1, '1, '1, '1, '1, 1'b1, 1'b1, '1));
        // continuation after the two solo cells, sequence lines up but nothing is open
        cell_backlog.push_back(cell_of('1, 32'h0000, 32'h010, 1'b0, 1'b1));
        // cell sequence wraps through zero
        cell_backlog.push_back(cell_of(32'h5, 32'hFFFE, 32'd100, 1'b1, 1'b0));
        cell_backlog.push_back(cell_of(32'h5, 32'hFFFF, 32'd200, 1'b0, 1'b0));
        cell_backlog.push_back(cell_of(32'h5, 32'h0000, 32'd300, 1'b0, 1'b1));
        cell_backlog.push_back(cell_of(32'h7, 32'd0, 32'd1, 1'b1, 1'b0));
        cell_backlog.push_back(cell_of(32'h8, 32'd1, 32'd2, 1'b0, 1'b1));
        cell_backlog.push_back(cell_of(32'h7, 32'd2, 32'd4, 1'b0, 1'b0));
        cell_backlog.push_back(cell_of(32'h7, 32'd0, 32'd8, 1'b0, 1'b0));
        cell_backlog.push_back(cell_of(32'h7, 32'd1, 32'd16, 1'b0, 1'b0));
        // new start while busy abandons message 7
        cell_backlog.push_back(cell_of(32'h9, 32'd10, 32'd32, 1'b1, 1'b0));
        cell_backlog.push_back(cell_of(32'h7, 32'd2, 32'd64, 1'b0, 1'b1));
        cell_backlog.push_back(cell_of(32'h9, 32'd11, 32'd128, 1'b0, 1'b1));
        cell_backlog.push_back(cell_of(32'h9, 32'd12, 32'd256, 1'b0, 1'b1));

        while (cell_backlog.size() < CELL_COUNT)
        begin
            if (!sat_done && cell_backlog.size() > 600)
            begin
                // long enough at full payload to pin the length at its maximum
                queue_message(258, 1'b0, 1'b1);
                sat_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
                cell_backlog.push_back(make_cell($urandom, $urandom,
                                                 (($urandom_range(0, 1) != 0) ?
                                                  asm_msg : $urandom),
                                                 $urandom, $urandom,
                                                 $urandom_range(0, 1) != 0,
                                                 $urandom_range(0, 1) != 0, $urandom));
            else
                queue_message($urandom_range(1, 8), $urandom_range(0, 3) == 0, 1'b0);
        end
        cells_total = cell_backlog.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cells_taken != cells_total) @(posedge clk);
        while (pkts_owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed && pkts_owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // cell driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cell_valid && cell_ready)
            begin
                reassemble_cell(cell_data);
                cells_taken = cells_taken + 1;
            end
            if (tx_mode_left == 0)
            begin
                tx_mode      <= $urandom_range(0, 2);
                tx_mode_left <= $urandom_range(50, 200);
            end
            else
                tx_mode_left <= tx_mode_left - 1;
            if (!cell_valid || cell_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap     <= tx_gap - 1;
                    cell_valid <= 1'b0;
                end
                else if (cell_backlog.size() == 0)
                    cell_valid <= 1'b0;
                else if (!calm() && tx_mode != 0 &&
                         $urandom_range(0, (tx_mode == 1) ? 7 : 2) == 0)
                begin
                    tx_gap     <= $urandom_range(0, 7);
                    cell_valid <= 1'b0;
                end
                else
                begin
                    cell_data  <= cell_backlog.pop_front();
                    cell_valid <= 1'b1;
                end
            end
        end
    end

    // packet monitor
    always @(posedge clk)
    begin : rx_side
        cellrc_pkg::pkt_t want;
        if (rst_n)
        begin
            if (pkt_valid && pkt_ready)
            begin
                if (pkts_owed.size() == 0)
                begin
                    $error("packet transfer with none expected, msg %0h", pkt.out_msg_seq);
                    failed = 1'b1;
                end
                else
                begin
                    want = pkts_owed.pop_front();
                    check_field("out_source", 32'(want.out_source), 32'(pkt.out_source));
                    check_field("out_dest", 32'(want.out_dest), 32'(pkt.out_dest));
                    check_field("out_msg_seq", want.out_msg_seq, pkt.out_msg_seq);
                    check_field("out_time", want.out_time, pkt.out_time);
                    check_field("total_bits", 32'(want.total_bits), 32'(pkt.total_bits));
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(50, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            if (rx_gap != 0)
            begin
                rx_gap    <= rx_gap - 1;
                pkt_ready <= 1'b0;
            end
            else if (!calm() && rx_mode != 0 &&
                     $urandom_range(0, (rx_mode == 1) ? 7 : 2) == 0)
            begin
                rx_gap    <= $urandom_range(0, 7);
                pkt_ready <= 1'b0;
            end
            else
                pkt_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
